### sv/icd_pkg.sv
// icd_pkg: types, constants and helpers shared by the duration parser modules.
// No dependencies; every other file in sv/ refers to it by scoped names.
package icd_pkg;

  localparam int MAG_BITS  = 40;
  localparam int SEC_BITS  = MAG_BITS + 1;
  localparam int UNIT_BITS = 20;
  localparam int LO_BITS   = (MAG_BITS + 1) / 2;
  localparam int HI_BITS   = MAG_BITS - LO_BITS;
  localparam int FULL_BITS = MAG_BITS + UNIT_BITS + 1;
  localparam int DIG_BITS  = MAG_BITS + 4;

  localparam logic [MAG_BITS-1:0] MAG_MAX = '1;

  localparam int CLS_DEPTH = 4;
  localparam int CLS_PTR_BITS = $clog2(CLS_DEPTH);
  localparam int CLS_CNT_BITS = $clog2(CLS_DEPTH + 1);
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_BITS = $clog2(RES_DEPTH);
  localparam int RES_CNT_BITS = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic signed [SEC_BITS-1:0] seconds;
    logic                       status;
  } out_word_t;

  typedef enum logic [3:0] {
    CLS_PLUS,
    CLS_MINUS,
    CLS_P,
    CLS_T,
    CLS_DIGIT,
    CLS_W,
    CLS_D,
    CLS_H,
    CLS_M,
    CLS_S,
    CLS_OTHER
  } char_cls_t;

  typedef struct packed {
    char_cls_t  cls;
    logic [3:0] digit;
    logic       last;
  } cls_word_t;

  typedef enum logic [2:0] {
    UNIT_NONE,
    UNIT_WEEK,
    UNIT_DAY,
    UNIT_HOUR,
    UNIT_MIN,
    UNIT_SEC
  } unit_t;

  typedef struct packed {
    unit_t               unit;
    logic [MAG_BITS-1:0] count;
    logic                last;
    logic                bad;
    logic                neg;
  } op_t;

  function automatic logic [UNIT_BITS-1:0] unit_secs(input unit_t u);
    logic [UNIT_BITS-1:0] v;
    v = '0;
    unique case (u)
      UNIT_WEEK: v = UNIT_BITS'(604800);
      UNIT_DAY:  v = UNIT_BITS'(86400);
      UNIT_HOUR: v = UNIT_BITS'(3600);
      UNIT_MIN:  v = UNIT_BITS'(60);
      UNIT_SEC:  v = UNIT_BITS'(1);
      default:   v = '0;
    endcase
    return v;
  endfunction

endpackage

### sv/icd_front.sv
// icd_front: classifies each text byte and holds the classified words in a short queue.
// Depends on icd_pkg.
module icd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  icd_pkg::in_word_t    item,
  output logic                 cls_valid,
  input  logic                 cls_ready,
  output icd_pkg::cls_word_t   cls_word
);

  icd_pkg::cls_word_t                  mem [icd_pkg::CLS_DEPTH];
  logic [icd_pkg::CLS_PTR_BITS-1:0]    wr_ptr;
  logic [icd_pkg::CLS_PTR_BITS-1:0]    rd_ptr;
  logic [icd_pkg::CLS_CNT_BITS-1:0]    count;
  logic                                wr_en;
  logic                                rd_en;
  logic [7:0]                          ch;
  logic [7:0]                          up;
  icd_pkg::cls_word_t                  cls_in;

  always_comb begin
    ch = item.text_byte;
    up = (ch >= 8'h61 && ch <= 8'h7a) ? ch - 8'd32 : ch;
    cls_in.last  = item.last_byte;
    cls_in.digit = ch[3:0];
    if (ch >= 8'h30 && ch <= 8'h39) begin
      cls_in.cls = icd_pkg::CLS_DIGIT;
    end else if (ch == 8'h2b) begin
      cls_in.cls = icd_pkg::CLS_PLUS;
    end else if (ch == 8'h2d) begin
      cls_in.cls = icd_pkg::CLS_MINUS;
    end else begin
      case (up)
        8'h50:   cls_in.cls = icd_pkg::CLS_P;
        8'h54:   cls_in.cls = icd_pkg::CLS_T;
        8'h57:   cls_in.cls = icd_pkg::CLS_W;
        8'h44:   cls_in.cls = icd_pkg::CLS_D;
        8'h48:   cls_in.cls = icd_pkg::CLS_H;
        8'h4d:   cls_in.cls = icd_pkg::CLS_M;
        8'h53:   cls_in.cls = icd_pkg::CLS_S;
        default: cls_in.cls = icd_pkg::CLS_OTHER;
      endcase
    end
  end

  assign full      = (count == icd_pkg::CLS_CNT_BITS'(icd_pkg::CLS_DEPTH));
  assign cls_valid = (count != '0);
  assign cls_word  = mem[rd_ptr];
  assign wr_en     = push && !full;
  assign rd_en     = cls_valid && cls_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= cls_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/icd_back.sv
// icd_back: parse state, unit multiply and saturating running total per classified word.
// Depends on icd_pkg.
module icd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cls_valid,
  output logic                 cls_ready,
  input  icd_pkg::cls_word_t   cls_word,
  input  logic                 res_full,
  output logic                 res_push,
  output icd_pkg::out_word_t   res_word
);

  typedef enum logic [2:0] {
    PH_START  = 3'b001,
    PH_NEED_P = 3'b010,
    PH_BODY   = 3'b100
  } phase_t;

  logic                             adv;
  logic                             take;

  phase_t                           phase, phase_next;
  logic                             negative, negative_next;
  logic                             after_t, after_t_next;
  logic                             pending, pending_next;
  logic                             malformed, malformed_next;
  logic [icd_pkg::MAG_BITS-1:0]     accum, accum_next;
  logic [icd_pkg::DIG_BITS-1:0]     times10;
  icd_pkg::op_t                     op_next;

  logic                             a_valid;
  icd_pkg::op_t                     a_op;

  logic                             b1_valid;
  logic                             b1_last, b1_bad, b1_neg;
  logic [icd_pkg::LO_BITS+icd_pkg::UNIT_BITS-1:0] p_lo;
  logic [icd_pkg::HI_BITS+icd_pkg::UNIT_BITS-1:0] p_hi;
  logic [icd_pkg::UNIT_BITS-1:0]    unit_val;

  logic                             b2_valid;
  logic                             b2_last, b2_bad, b2_neg;
  logic [icd_pkg::MAG_BITS-1:0]     prod;
  logic [icd_pkg::FULL_BITS-1:0]    full_prod;

  logic [icd_pkg::MAG_BITS-1:0]     total;
  logic [icd_pkg::MAG_BITS:0]       sum;
  logic [icd_pkg::MAG_BITS-1:0]     sum_sat;
  logic [icd_pkg::SEC_BITS-1:0]     mag_ext;

  assign adv       = !res_full;
  assign cls_ready = adv;
  assign take      = adv && cls_valid;

  // parse one classified word
  always_comb begin
    phase_next     = phase;
    negative_next  = negative;
    after_t_next   = after_t;
    pending_next   = pending;
    malformed_next = malformed;
    accum_next     = accum;
    op_next.unit   = icd_pkg::UNIT_NONE;
    op_next.count  = accum;
    op_next.last   = cls_word.last;
    op_next.bad    = 1'b0;
    op_next.neg    = 1'b0;
    times10 = (icd_pkg::DIG_BITS'(accum) << 3) + (icd_pkg::DIG_BITS'(accum) << 1)
              + icd_pkg::DIG_BITS'(cls_word.digit);
    if (!malformed) begin
      unique case (phase)
        PH_START: begin
          case (cls_word.cls)
            icd_pkg::CLS_PLUS:  phase_next = PH_NEED_P;
            icd_pkg::CLS_MINUS: begin
              phase_next    = PH_NEED_P;
              negative_next = 1'b1;
            end
            icd_pkg::CLS_P:     phase_next = PH_BODY;
            default:            malformed_next = 1'b1;
          endcase
        end
        PH_NEED_P: begin
          if (cls_word.cls == icd_pkg::CLS_P) begin
            phase_next = PH_BODY;
          end else begin
            malformed_next = 1'b1;
          end
        end
        PH_BODY: begin
          if (cls_word.cls == icd_pkg::CLS_DIGIT) begin
            accum_next = (times10 > icd_pkg::DIG_BITS'(icd_pkg::MAG_MAX)) ?
                         icd_pkg::MAG_MAX : times10[icd_pkg::MAG_BITS-1:0];
            pending_next = 1'b1;
          end else if (cls_word.cls == icd_pkg::CLS_T && !pending) begin
            after_t_next = 1'b1;
          end else if (!pending) begin
            malformed_next = 1'b1;
          end else begin
            case (cls_word.cls)
              icd_pkg::CLS_W: op_next.unit = icd_pkg::UNIT_WEEK;
              icd_pkg::CLS_D: op_next.unit = icd_pkg::UNIT_DAY;
              icd_pkg::CLS_H: op_next.unit = icd_pkg::UNIT_HOUR;
              icd_pkg::CLS_M: op_next.unit = after_t ? icd_pkg::UNIT_MIN : icd_pkg::UNIT_NONE;
              icd_pkg::CLS_S: op_next.unit = icd_pkg::UNIT_SEC;
              default:        malformed_next = 1'b1;
            endcase
            if (cls_word.cls inside {icd_pkg::CLS_W, icd_pkg::CLS_D, icd_pkg::CLS_H,
                                     icd_pkg::CLS_M, icd_pkg::CLS_S}) begin
              accum_next   = '0;
              pending_next = 1'b0;
            end
          end
        end
        default: malformed_next = 1'b1;
      endcase
    end
    op_next.bad = malformed_next || pending_next || (phase_next != PH_BODY);
    op_next.neg = negative_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_START;
      negative  <= 1'b0;
      after_t   <= 1'b0;
      pending   <= 1'b0;
      malformed <= 1'b0;
      accum     <= '0;
    end else if (take) begin
      if (cls_word.last) begin
        phase     <= PH_START;
        negative  <= 1'b0;
        after_t   <= 1'b0;
        pending   <= 1'b0;
        malformed <= 1'b0;
        accum     <= '0;
      end else begin
        phase     <= phase_next;
        negative  <= negative_next;
        after_t   <= after_t_next;
        pending   <= pending_next;
        malformed <= malformed_next;
        accum     <= accum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_op <= op_next;
    end
  end

  // split multiply by the unit in seconds
  assign unit_val = icd_pkg::unit_secs(a_op.unit);

  always_ff @(posedge clk) begin
    if (adv) begin
      p_lo <= (icd_pkg::LO_BITS+icd_pkg::UNIT_BITS)'(a_op.count[icd_pkg::LO_BITS-1:0])
              * (icd_pkg::LO_BITS+icd_pkg::UNIT_BITS)'(unit_val);
      p_hi <= (icd_pkg::HI_BITS+icd_pkg::UNIT_BITS)'(
                a_op.count[icd_pkg::MAG_BITS-1:icd_pkg::LO_BITS])
              * (icd_pkg::HI_BITS+icd_pkg::UNIT_BITS)'(unit_val);
      b1_last <= a_op.last;
      b1_bad  <= a_op.bad;
      b1_neg  <= a_op.neg;
    end
  end

  // combine partial products and saturate
  assign full_prod = (icd_pkg::FULL_BITS'(p_hi) << icd_pkg::LO_BITS)
                     + icd_pkg::FULL_BITS'(p_lo);

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= (full_prod > icd_pkg::FULL_BITS'(icd_pkg::MAG_MAX)) ?
              icd_pkg::MAG_MAX : full_prod[icd_pkg::MAG_BITS-1:0];
      b2_last <= b1_last;
      b2_bad  <= b1_bad;
      b2_neg  <= b1_neg;
    end
  end

  // accumulate, and finish the text on its last word
  assign sum     = {1'b0, total} + {1'b0, prod};
  assign sum_sat = sum[icd_pkg::MAG_BITS] ? icd_pkg::MAG_MAX : sum[icd_pkg::MAG_BITS-1:0];
  assign mag_ext = {1'b0, sum_sat};

  always_comb begin
    res_push        = adv && b2_valid && b2_last;
    res_word.status = b2_bad;
    if (b2_bad) begin
      res_word.seconds = '0;
    end else if (b2_neg) begin
      res_word.seconds = -mag_ext;
    end else begin
      res_word.seconds = mag_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
      total    <= '0;
    end else if (adv) begin
      a_valid  <= take;
      b1_valid <= a_valid;
      b2_valid <= b1_valid;
      if (b2_valid) begin
        total <= b2_last ? '0 : sum_sat;
      end
    end
  end

endmodule

### sv/icd_resq.sv
// icd_resq: result queue between the parse pipeline and the result channel.
// Depends on icd_pkg.
module icd_resq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 res_push,
  input  icd_pkg::out_word_t   res_word,
  output logic                 res_full,
  output logic                 empty,
  input  logic                 pop,
  output icd_pkg::out_word_t   result
);

  icd_pkg::out_word_t                  mem [icd_pkg::RES_DEPTH];
  logic [icd_pkg::RES_PTR_BITS-1:0]    wr_ptr;
  logic [icd_pkg::RES_PTR_BITS-1:0]    rd_ptr;
  logic [icd_pkg::RES_CNT_BITS-1:0]    count;
  logic                                wr_en;
  logic                                rd_en;

  assign res_full = (count == icd_pkg::RES_CNT_BITS'(icd_pkg::RES_DEPTH));
  assign empty    = (count == '0);
  assign result   = mem[rd_ptr];
  assign wr_en    = res_push && !res_full;
  assign rd_en    = pop && !empty;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= res_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/ical_duration_parser_top.sv
// ical_duration_parser_top: duration text parser, top level.
// Depends on icd_pkg, icd_front, icd_back and icd_resq.
//
// Input channel: one text byte and its last flag per word, taken when push is
// high and full is low. Letters may be either case; optional sign, then P, then
// <digits><unit> groups with an optional T. Result channel: one word per text,
// on its last byte: signed seconds (zero when malformed) and status (1 =
// malformed). The oldest result is shown while empty is low and leaves on pop.
// Throughput: one byte per cycle while the result queue has room. After its last
// byte is taken, a result passes the classify queue, parse stage, two multiply
// stages and result queue before it is visible. The 40 by 20 unit multiply is
// split into two 20 by 20 halves that the next stage combines.
// Reset (rst, synchronous) empties both queues and returns the parse state to
// "expect sign or P". When the receiver stops popping, the result queue fills,
// the parse pipeline holds, the classify queue fills and full rises; no word
// is dropped.
module ical_duration_parser_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  icd_pkg::in_word_t    item,
  output logic                 empty,
  input  logic                 pop,
  output icd_pkg::out_word_t   result
);

  logic                 cls_valid;
  logic                 cls_ready;
  icd_pkg::cls_word_t   cls_word;
  logic                 res_full;
  logic                 res_push;
  icd_pkg::out_word_t   res_word;

  icd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cls_valid (cls_valid),
    .cls_ready (cls_ready),
    .cls_word  (cls_word)
  );

  icd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cls_valid (cls_valid),
    .cls_ready (cls_ready),
    .cls_word  (cls_word),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_word  (res_word)
  );

  icd_resq u_resq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_word (res_word),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule
